// ===== src/sparse_projection_dot_product_top_defines.svh =====
// Assertion helpers for the projection dot product block.
// Each check runs on the rising clock and is held off while reset is asserted.
`ifndef SPARSE_PROJECTION_DOT_PRODUCT_TOP_DEFINES_SVH
`define SPARSE_PROJECTION_DOT_PRODUCT_TOP_DEFINES_SVH

// Same-cycle implication.
`define SPDP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("spdp check failed");

// Next-cycle implication.
`define SPDP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("spdp check failed");

`endif

// ===== src/spdp_pkg.sv =====
package spdp_pkg;

  // Config register index width; indexes past the last register are ignored
  localparam int unsigned CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INDEX_OFFSET  = 8'd0,
    CFG_WEIGHT_MASK   = 8'd1,
    CFG_COLUMN_NUMBER = 8'd2,
    CFG_HASH_SEED     = 8'd3
  } cfg_reg_e;

  // Multiplier used to combine the two indexes of a quadratic pair
  localparam logic [24:0] PAIR_PRIME = 25'd16777619;

  // Feature kinds
  localparam logic CMD_LINEAR = 1'b0;
  localparam logic CMD_PAIR   = 1'b1;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef struct packed {
    logic               cmd;
    logic [63:0]        first_index;
    logic signed [31:0] first_value;
    logic [63:0]        second_index;
    logic signed [31:0] second_value;
    logic               last;
  } in_req_t;

  typedef struct packed {
    logic signed [47:0] dot_sum;
    logic               saturated;
  } out_rsp_t;

endpackage

// ===== src/sparse_projection_dot_product_top.sv =====
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (spdp_pkg::in_req_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (spdp_pkg::out_rsp_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One feature is taken every cycle unless the pipeline holds; a six-stage pipeline feeds one 48-bit
// saturating accumulator, the only loop-carried path.
// The sum for an example is written to the output register when its last feature leaves stage 6.
// The whole pipeline holds only while a finished sum waits in the output register.
// Reset clears the config registers to their defaults, the accumulator and flag.
// Config writes are always taken (cfg_ready_o is tied high).
module sparse_projection_dot_product_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  spdp_pkg::in_req_t                in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output spdp_pkg::out_rsp_t               out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spdp_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [63:0]                      cfg_data_i
);
  import spdp_pkg::*;
  `include "sparse_projection_dot_product_top_defines.svh"

  // Stage payloads
  typedef struct packed {
    logic               cmd;
    logic               last;
    logic [63:0]        first_index;
    logic [63:0]        second_index;
    logic signed [31:0] first_value;
    logic [63:0]        prod;
    logic [56:0]        mul_lo;
    logic [31:0]        mul_hi;
  } s2_t;

  typedef struct packed {
    logic               last;
    logic               sat;
    logic [63:0]        idx;
    logic signed [31:0] val;
  } s3_t;

  typedef struct packed {
    logic               last;
    logic               sat;
    logic [63:0]        pos;
    logic signed [31:0] val;
  } s4_t;

  typedef struct packed {
    logic               last;
    logic               sat;
    logic               nonzero;
    logic               negate;
    logic signed [31:0] val;
  } s6_t;

  logic [63:0] index_offset_q, weight_mask_q, column_number_q, hash_seed_q;

  logic     advance;
  logic     s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q, s6_valid_q;
  in_req_t  s1_q;
  s2_t      s2_q, s2_d;
  s3_t      s3_q, s3_d;
  s4_t      s4_q, s4_d, s5_q, s5_d;
  s6_t      s6_q, s6_d;

  logic signed [47:0] acc_q, acc_d;
  logic               seen_q, seen_d;
  logic               out_valid_q;
  out_rsp_t           out_q;

  // Whole pipeline moves unless a result is stuck in the output register
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_offset_q  <= '0;
      weight_mask_q   <= '1;
      column_number_q <= '0;
      hash_seed_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INDEX_OFFSET:  index_offset_q  <= cfg_data_i;
        CFG_WEIGHT_MASK:   weight_mask_q   <= cfg_data_i;
        CFG_COLUMN_NUMBER: column_number_q <= cfg_data_i;
        CFG_HASH_SEED:     hash_seed_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 2: value product and split index product
  logic [56:0] mul_hi_full;
  always_comb begin
    s2_d.cmd          = s1_q.cmd;
    s2_d.last         = s1_q.last;
    s2_d.first_index  = s1_q.first_index;
    s2_d.second_index = s1_q.second_index;
    s2_d.first_value  = s1_q.first_value;
    // signed 32 x 32 product
    s2_d.prod         = s1_q.first_value * s1_q.second_value;
    s2_d.mul_lo       = {25'b0, s1_q.first_index[31:0]} * {32'b0, PAIR_PRIME};
    mul_hi_full       = {25'b0, s1_q.first_index[63:32]} * {32'b0, PAIR_PRIME};
    s2_d.mul_hi       = mul_hi_full[31:0];
  end

  // Stage 3: pair index, rounded and clamped pair value
  logic [63:0] rnd;
  always_comb begin
    rnd       = s2_q.prod + 64'd32768;
    s3_d.last = s2_q.last;
    s3_d.sat  = 1'b0;
    s3_d.idx  = s2_q.first_index;
    s3_d.val  = s2_q.first_value;
    if (s2_q.cmd == CMD_PAIR) begin
      s3_d.idx = s2_q.second_index ^ ({7'b0, s2_q.mul_lo} + {s2_q.mul_hi, 32'b0});
      // rnd[63:16] is the rounded product; it must fit in 32 bits
      if (rnd[63:47] == {17{rnd[63]}}) begin
        s3_d.val = rnd[47:16];
      end else begin
        s3_d.sat = 1'b1;
        s3_d.val = rnd[63] ? VAL_MIN : VAL_MAX;
      end
    end
  end

  // Stage 4: offset and mask
  always_comb begin
    s4_d      = '0;
    s4_d.last = s3_q.last;
    s4_d.sat  = s3_q.sat;
    s4_d.val  = s3_q.val;
    s4_d.pos  = (s3_q.idx + index_offset_q) & weight_mask_q;
  end

  // Stage 5: column add
  always_comb begin
    s5_d     = s4_q;
    s5_d.pos = s4_q.pos + column_number_q;
  end

  // Stage 6: sign matrix entry from the two parities
  always_comb begin
    s6_d.last    = s5_q.last;
    s6_d.sat     = s5_q.sat;
    s6_d.val     = s5_q.val;
    s6_d.nonzero = ^s5_q.pos;
    s6_d.negate  = ^(s5_q.pos + hash_seed_q);
  end

  // Accumulate: negation folded into the adder as invert plus carry in
  logic [47:0] addend;
  logic [48:0] sum;
  logic        acc_sat;
  always_comb begin
    addend  = {{16{s6_q.val[31]}}, s6_q.val} ^ {48{s6_q.negate}};
    sum     = {acc_q[47], acc_q} + {addend[47], addend} + {48'b0, s6_q.negate};
    acc_sat = 1'b0;
    acc_d   = acc_q;
    if (s6_q.nonzero) begin
      if (sum[48] != sum[47]) begin
        acc_sat = 1'b1;
        acc_d   = sum[48] ? ACC_MIN : ACC_MAX;
      end else begin
        acc_d = sum[47:0];
      end
    end
    seen_d = seen_q || s6_q.sat || acc_sat;
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q <= in_data_i;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
    end
  end

  // Accumulator, flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance && s6_valid_q) begin
        if (s6_q.last) begin
          acc_q  <= '0;
          seen_q <= 1'b0;
        end else begin
          acc_q  <= acc_d;
          seen_q <= seen_d;
        end
      end
      // a new sum wins over the drain of the old one
      if (advance && s6_valid_q && s6_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s6_valid_q && s6_q.last) begin
      out_q.dot_sum   <= acc_d;
      out_q.saturated <= seen_d;
    end
  end

  // Checks
  `SPDP_ASSERT_NEXT(a_last_emits, advance && s6_valid_q && s6_q.last, out_valid_o)
  `SPDP_ASSERT_NEXT(a_last_clears, advance && s6_valid_q && s6_q.last, acc_q == '0 && !seen_q)
  `SPDP_ASSERT_NEXT(a_linear_no_sat, advance && s2_valid_q && s2_q.cmd == CMD_LINEAR, !s3_q.sat)
  `SPDP_ASSERT_NEXT(a_stall_holds_acc, !advance, $stable(acc_q) && $stable(seen_q))
  `SPDP_ASSERT_NOW(a_stall_only_on_output, !in_ready_o, out_valid_o)

endmodule

// ===== bench/sparse_projection_dot_product_top_tb.sv =====
`timescale 1ns / 1ps

module sparse_projection_dot_product_top_tb;
  import spdp_pkg::*;

  localparam int unsigned RunLimit    = 1_000_000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned RandomItems = 750;
  localparam int unsigned SignRun     = 40;

  // register indexes past the last real register; writes there are dropped
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = 8'hFF;

  // handy Q16.16 values
  localparam logic signed [31:0] QOne  = 32'sh0001_0000;
  localparam logic signed [31:0] QHalf = 32'sh0000_8000;
  localparam logic signed [31:0] QLsb  = 32'sh0000_0001;
  localparam logic signed [31:0] QNegLsb = -32'sh0000_0001;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_ready_o;
  in_req_t            in_data = '0;
  logic               out_valid_o;
  logic               out_ready = 1'b0;
  out_rsp_t           out_data_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0]        cfg_data = '0;

  // shadow copy of the block's registers and running state
  logic [63:0]        cur_offset = '0;
  logic [63:0]        cur_mask   = '1;
  logic [63:0]        cur_column = '0;
  logic [63:0]        cur_seed   = '0;
  logic signed [47:0] run_sum     = '0;
  logic               run_clipped = 1'b0;
  out_rsp_t           sum_q[$];
  out_rsp_t           want;

  int unsigned in_idle_pct  = 20;
  int unsigned out_idle_pct = 20;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  int unsigned cycle_count = 0;
  int unsigned n_errors = 0;
  int unsigned n_features = 0;
  int unsigned n_sums = 0;
  int unsigned n_cfg_writes = 0;
  int unsigned n_in_stalls = 0;

  sparse_projection_dot_product_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("timeout after %0d cycles, %0d sums outstanding", cycle_count, sum_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // long output hold: counted here, started by a one-cycle pulse
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output ready with random stalls
  always @(posedge clk_i) begin
    out_ready <= !hold_go && (hold_left == 0) && ($urandom_range(99) >= out_idle_pct);
  end

  // input backpressure seen by the sender
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_ready_o) begin
      n_in_stalls <= n_in_stalls + 1;
    end
  end

  task automatic flag_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // check each accepted sum against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (sum_q.size() == 0) begin
        flag_mismatch($sformatf("sum %0d with nothing expected", out_data_o.dot_sum));
      end else begin
        want = sum_q.pop_front();
        n_sums++;
        if (out_data_o.dot_sum !== want.dot_sum) begin
          flag_mismatch($sformatf("dot_sum %0d, expected %0d",
                                  out_data_o.dot_sum, want.dot_sum));
        end
        if (out_data_o.saturated !== want.saturated) begin
          flag_mismatch($sformatf("saturated %0b, expected %0b",
                                  out_data_o.saturated, want.saturated));
        end
      end
    end
  end

  // Fold one accepted feature into the shadow sum; queue the sum on last.
  function automatic void accumulate_feature(input in_req_t f);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] prod;
    logic signed [63:0] rnd;
    logic signed [31:0] term;
    logic signed [47:0] contrib;
    logic [63:0]        feat_idx;
    logic [63:0]        pos;
    logic [63:0]        signed_pos;
    logic [48:0]        wide;
    logic               clip;
    out_rsp_t           done;
    clip = 1'b0;
    feat_idx = f.first_index;
    term = f.first_value;
    if (f.cmd == CMD_PAIR) begin
      a = {{32{f.first_value[31]}}, f.first_value};
      b = {{32{f.second_value[31]}}, f.second_value};
      prod = a * b;
      // round half up, then clip to Q16.16
      rnd = (prod + 64'sd32768) >>> 16;
      if (rnd > 64'sh0000_0000_7FFF_FFFF) begin
        term = VAL_MAX;
        clip = 1'b1;
      end else if (rnd < 64'shFFFF_FFFF_8000_0000) begin
        term = VAL_MIN;
        clip = 1'b1;
      end else begin
        term = rnd[31:0];
      end
      feat_idx = f.second_index ^ (f.first_index * {39'd0, PAIR_PRIME});
    end
    pos = ((feat_idx + cur_offset) & cur_mask) + cur_column;
    if (^pos) begin
      contrib = {{16{term[31]}}, term};
      signed_pos = pos + cur_seed;
      if (^signed_pos) begin
        contrib = -contrib;
      end
      wide = {run_sum[47], run_sum} + {contrib[47], contrib};
      if (wide[48] != wide[47]) begin
        run_sum = wide[48] ? ACC_MIN : ACC_MAX;
        clip = 1'b1;
      end else begin
        run_sum = wide[47:0];
      end
    end
    run_clipped = run_clipped | clip;
    if (f.last) begin
      done.dot_sum = run_sum;
      done.saturated = run_clipped;
      sum_q.push_back(done);
      run_sum = '0;
      run_clipped = 1'b0;
    end
  endfunction

  // Offer one request, with an occasional gap in front, and wait for it to be taken.
  task automatic send_feature(input in_req_t f);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk_i); while (!in_ready_o);
    n_features++;
    accumulate_feature(f);
  endtask

  task automatic send_item(input logic cmd, input logic [63:0] idx_a,
                           input logic signed [31:0] val_a, input logic [63:0] idx_b,
                           input logic signed [31:0] val_b, input logic is_last);
    in_req_t f;
    f.cmd = cmd;
    f.first_index = idx_a;
    f.first_value = val_a;
    f.second_index = idx_b;
    f.second_value = val_b;
    f.last = is_last;
    send_feature(f);
  endtask

  // Drop valid, wait for every queued sum, then let the pipeline empty.
  task automatic wait_sums_drained();
    in_valid <= 1'b0;
    while (sum_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all four registers back to back, then one write to an unused index.
  task automatic program_projection(input logic [63:0] offset, input logic [63:0] mask,
                                    input logic [63:0] column, input logic [63:0] seed);
    logic [CfgIdxW-1:0] reg_idx[5];
    logic [63:0]        reg_val[5];
    reg_idx = '{CFG_INDEX_OFFSET, CFG_WEIGHT_MASK, CFG_COLUMN_NUMBER, CFG_HASH_SEED,
                CfgIdxW'($urandom_range(CfgIdxTop, CfgIdxSpare))};
    reg_val = '{offset, mask, column, seed, {$urandom, $urandom}};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_idx[k];
      cfg_data <= reg_val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      n_cfg_writes++;
      case (reg_idx[k])
        CFG_INDEX_OFFSET:  cur_offset = reg_val[k];
        CFG_WEIGHT_MASK:   cur_mask = reg_val[k];
        CFG_COLUMN_NUMBER: cur_column = reg_val[k];
        CFG_HASH_SEED:     cur_seed = reg_val[k];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] random_index();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2, 3: return int'($urandom_range(262143)) - 131072;
      default: return $urandom;
    endcase
  endfunction

  // Reset registers: every nonzero entry carries a minus sign.
  task automatic test_reset_defaults();
    send_item(CMD_LINEAR, 64'd1, VAL_MAX, '1, VAL_MIN, 1'b0);
    send_item(CMD_LINEAR, '0, VAL_MIN, '1, VAL_MAX, 1'b0);
    send_item(CMD_LINEAR, '1, VAL_MAX, '0, VAL_MAX, 1'b0);
    send_item(CMD_LINEAR, 64'h8000_0000_0000_0000, VAL_MIN, '0, '0, 1'b1);
    send_item(CMD_LINEAR, 64'h7FFF_FFFF_FFFF_FFFF, QLsb, random_index(), random_value(), 1'b1);
    send_item(CMD_PAIR, '1, QOne, '0, QOne, 1'b1);
    wait_sums_drained();
  endtask

  // Pair products: rounding at one half, clipping at both ends.
  task automatic test_pair_products();
    program_projection('0, '1, '0, 64'd1);
    send_item(CMD_PAIR, 64'd3, QLsb, 64'd5, QHalf, 1'b1);
    send_item(CMD_PAIR, 64'd3, QNegLsb, 64'd5, QHalf, 1'b1);
    send_item(CMD_PAIR, 64'd7, QNegLsb, 64'd1, QNegLsb, 1'b1);
    send_item(CMD_PAIR, '0, QOne, 64'd1, QOne, 1'b1);
    send_item(CMD_PAIR, '1, VAL_MIN, '0, VAL_MIN, 1'b1);
    send_item(CMD_PAIR, '0, VAL_MIN, '1, VAL_MAX, 1'b1);
    send_item(CMD_PAIR, '1, VAL_MAX, '1, VAL_MAX, 1'b1);
    send_item(CMD_PAIR, 64'h0123_4567_89AB_CDEF, QHalf, 64'hFEDC_BA98_7654_3210, QHalf, 1'b1);
    wait_sums_drained();
  endtask

  // Mask of zero pins every feature to the column: negating the most negative value.
  task automatic test_negate_min();
    program_projection('1, '0, 64'd1, '0);
    send_item(CMD_LINEAR, random_index(), VAL_MIN, '0, '0, 1'b1);
    send_item(CMD_PAIR, random_index(), VAL_MIN, random_index(), QOne, 1'b0);
    send_item(CMD_LINEAR, random_index(), VAL_MIN, '0, '0, 1'b1);
    wait_sums_drained();
  endtask

  // Receiver holds off while the sender keeps pushing short examples.
  task automatic test_output_hold();
    program_projection(random_index(), random_index(), random_index(), random_index());
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;
    for (int k = 0; k < 60; k++) begin
      send_item($urandom_range(1), random_index(), random_value(), random_index(),
                random_value(), ($urandom_range(2) != 0) || (k == 59));
    end
    wait_sums_drained();
    in_idle_pct = 20;
    out_idle_pct = 20;
  endtask

  // Long same-sign runs of the most negative value, with and without the sign flip.
  task automatic test_same_sign_runs();
    in_req_t f;
    f = '0;
    f.cmd = CMD_LINEAR;
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (int run = 0; run < 3; run++) begin
      // seed 0 flips the sign at column 1, seed 2 keeps it
      program_projection(random_index(), '0, 64'd1, (run == 0) ? 64'd0 : 64'd2);
      for (int k = 0; k < SignRun + run / 2; k++) begin
        f.first_index = {$urandom, $urandom};
        f.first_value = VAL_MIN;
        f.second_index = {$urandom, $urandom};
        f.second_value = $urandom;
        f.last = (k == SignRun + run / 2 - 1);
        send_feature(f);
      end
      wait_sums_drained();
    end
    in_idle_pct = 20;
    out_idle_pct = 20;
  endtask

  // Random examples over several register settings, extremes first.
  task automatic test_random_examples();
    int unsigned sent;
    int unsigned span;
    logic [63:0] mask;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_projection('0, '0, '0, '0);
        1: program_projection('1, '1, '1, '1);
        2: program_projection(random_index(), random_index(), random_index(), random_index());
        3: program_projection({$urandom, $urandom}, '1, {$urandom, $urandom},
                              {$urandom, $urandom});
        default: begin
          mask = {$urandom, $urandom} & {$urandom, $urandom};
          program_projection({$urandom, $urandom}, mask, {$urandom, $urandom},
                             {$urandom, $urandom});
        end
      endcase
      // one phase runs with no idling on either side
      in_idle_pct = (phase == 3) ? 0 : 20;
      out_idle_pct = (phase == 3) ? 0 : 20;
      sent = 0;
      while (sent < RandomItems / 5) begin
        span = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
        for (int k = 0; k < span; k++) begin
          send_item($urandom_range(1), random_index(), random_value(), random_index(),
                    random_value(), k == span - 1);
        end
        sent += span;
      end
      wait_sums_drained();
    end
    in_idle_pct = 20;
    out_idle_pct = 20;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_pair_products();
    test_negate_min();
    test_output_hold();
    test_same_sign_runs();
    test_random_examples();

    wait_sums_drained();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d features into %0d checked sums across %0d register writes.",
             n_features, n_sums, n_cfg_writes);
    $display("Covered reset defaults, pair rounding and clipping, same-sign runs, and %0d %s",
             n_in_stalls, "cycles of input backpressure under output hold.");
    if (n_errors == 0 && sum_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d sums never seen", n_errors, sum_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
